// File: design/rfe_pkg.sv
package rfe_pkg;

  // Screen geometry
  localparam int SCREEN_W = 640;
  localparam int SCREEN_H = 480;

  // Column / row index widths and edge widths (an edge may equal the screen size)
  localparam int XW = $clog2(SCREEN_W);
  localparam int YW = $clog2(SCREEN_H);
  localparam int CW = $clog2(SCREEN_W + 1);
  localparam int RW = $clog2(SCREEN_H + 1);

  // Pixel memory
  localparam int MEM_D = SCREEN_W * SCREEN_H;
  localparam int AW    = $clog2(MEM_D);

  // Fixed field widths of the channels
  localparam int REQ_W = 3;
  localparam int POS_W = 13;
  localparam int PIX_W = 16;
  localparam int BXW   = 10;
  localparam int BYW   = 9;

  // Signed width for clipping sums of two position fields
  localparam int EW = POS_W + 2;

  // Command queue depth, power of two
  localparam int Q_DEPTH = 2;
  localparam int QAW     = $clog2(Q_DEPTH);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PIXEL   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FILL    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PATTERN = 3'd3;
  localparam logic [REQ_W-1:0] REQ_MARK    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_TAKE    = 3'd5;
  localparam logic [REQ_W-1:0] REQ_READ    = 3'd6;

  // Test pattern: color bars over the top rows, grey ramp below
  localparam int PAT_SPLIT = (SCREEN_H * 2) / 3;
  localparam int BAR_W     = SCREEN_W / 8;
  localparam int BAR_SH    = XW + $clog2(BAR_W);
  localparam longint BAR_M = ((longint'(1) << BAR_SH) + BAR_W - 1) / BAR_W;
  localparam int BAR_MW    = $clog2(BAR_M + 1);
  localparam int BAR_QW    = 4;
  localparam int BAR_LAST  = 7;

  localparam int GREY_D     = SCREEN_W - 1;
  localparam int GREY_SH    = XW + 8 + $clog2(GREY_D);
  localparam longint GREY_K = 255 * (((longint'(1) << GREY_SH) + GREY_D - 1) / GREY_D);
  localparam int GREY_KW    = $clog2(GREY_K + 1);

  localparam logic [PIX_W-1:0] BAR_COLORS [8] = '{
    16'hFFFF, 16'hFFE0, 16'h07FF, 16'h07E0, 16'hF81F, 16'hF800, 16'h001F, 16'h0000
  };

  // Operation handed from front to back
  typedef enum logic [1:0] {
    OP_NONE,
    OP_DRAW,
    OP_READ,
    OP_TAKE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             grow;
    logic             pat;
    logic [CW-1:0]    left;
    logic [CW-1:0]    right;
    logic [RW-1:0]    top;
    logic [RW-1:0]    bottom;
    logic [PIX_W-1:0] color;
  } cmd_t;

  // Test pattern value of one pixel; divisions by constants done as
  // exact reciprocal multiplies
  function automatic logic [PIX_W-1:0] pattern_rgb565(input logic [XW-1:0] x,
                                                       input logic [YW-1:0] y);
    logic [XW+BAR_MW-1:0]  bprod;
    logic [BAR_QW-1:0]     bq;
    logic [2:0]            bi;
    logic [XW+GREY_KW-1:0] gprod;
    logic [7:0]            g;
    logic [PIX_W-1:0]      v;
    bprod = (XW+BAR_MW)'(x) * (XW+BAR_MW)'(BAR_M);
    bq    = BAR_QW'(bprod >> BAR_SH);
    bi    = (bq > BAR_QW'(BAR_LAST)) ? 3'(BAR_LAST) : bq[2:0];
    gprod = (XW+GREY_KW)'(x) * (XW+GREY_KW)'(GREY_K);
    g     = 8'(gprod >> GREY_SH);
    if (y < YW'(PAT_SPLIT)) begin
      v = BAR_COLORS[bi];
    end else begin
      v = {g[7:3], g[7:2], g[7:3]};
    end
    return v;
  endfunction

endpackage

// File: design/rfe_req_if.sv
interface rfe_req_if import rfe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [POS_W-1:0] x_pos;
  logic signed [POS_W-1:0] y_pos;
  logic signed [POS_W-1:0] rect_w;
  logic signed [POS_W-1:0] rect_h;
  logic [PIX_W-1:0]        color;

  modport source (output valid, req_type, x_pos, y_pos, rect_w, rect_h, color,
                  input ready);
  modport sink (input valid, req_type, x_pos, y_pos, rect_w, rect_h, color,
                output ready);
endinterface

// File: design/rfe_rsp_if.sv
interface rfe_rsp_if import rfe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             dirty_valid;
  logic [BXW-1:0]   box_x;
  logic [BYW-1:0]   box_y;
  logic [BXW-1:0]   box_w;
  logic [BYW-1:0]   box_h;
  logic [PIX_W-1:0] pixel_out;

  modport source (output valid, dirty_valid, box_x, box_y, box_w, box_h, pixel_out,
                  input ready);
  modport sink (input valid, dirty_valid, box_x, box_y, box_w, box_h, pixel_out,
                output ready);
endinterface

// File: design/rfe_front.sv
module rfe_front import rfe_pkg::*; (
  rfe_req_if.sink  req,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  localparam logic signed [EW-1:0] W_S = EW'(SCREEN_W);
  localparam logic signed [EW-1:0] H_S = EW'(SCREEN_H);

  logic signed [EW-1:0] xs, ys, xe, ye, xp1, yp1;
  logic signed [EW-1:0] lft, top, rgt, bot;
  logic                 area_ok;
  logic                 pix_in;

  // Take an item whenever the queue has room
  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;

  // Clip the rectangle to the screen
  assign xs  = EW'(req.x_pos);
  assign ys  = EW'(req.y_pos);
  assign xe  = EW'(req.x_pos) + EW'(req.rect_w);
  assign ye  = EW'(req.y_pos) + EW'(req.rect_h);
  assign xp1 = xs + EW'(1);
  assign yp1 = ys + EW'(1);
  assign lft = (xs < 0) ? '0 : xs;
  assign top = (ys < 0) ? '0 : ys;
  assign rgt = (xe > W_S) ? W_S : xe;
  assign bot = (ye > H_S) ? H_S : ye;
  assign area_ok = (lft < rgt) && (top < bot);
  assign pix_in  = (xs >= 0) && (xs < W_S) && (ys >= 0) && (ys < H_S);

  // Classify the item into a back-end command
  always_comb begin
    q_cmd       = '0;
    q_cmd.op    = OP_NONE;
    q_cmd.color = req.color;
    unique case (req.req_type)
      REQ_PIXEL: begin
        if (pix_in) begin
          q_cmd.op     = OP_DRAW;
          q_cmd.grow   = 1'b1;
          q_cmd.left   = xs[CW-1:0];
          q_cmd.right  = xp1[CW-1:0];
          q_cmd.top    = ys[RW-1:0];
          q_cmd.bottom = yp1[RW-1:0];
        end
      end
      REQ_FILL, REQ_PATTERN: begin
        if (area_ok) begin
          q_cmd.op     = OP_DRAW;
          q_cmd.grow   = 1'b1;
          q_cmd.pat    = (req.req_type == REQ_PATTERN);
          q_cmd.left   = lft[CW-1:0];
          q_cmd.right  = rgt[CW-1:0];
          q_cmd.top    = top[RW-1:0];
          q_cmd.bottom = bot[RW-1:0];
        end
      end
      REQ_CLEAR: begin
        q_cmd.op     = OP_DRAW;
        q_cmd.grow   = 1'b1;
        q_cmd.left   = '0;
        q_cmd.right  = CW'(SCREEN_W);
        q_cmd.top    = '0;
        q_cmd.bottom = RW'(SCREEN_H);
      end
      REQ_MARK: begin
        if (area_ok) begin
          q_cmd.grow   = 1'b1;
          q_cmd.left   = lft[CW-1:0];
          q_cmd.right  = rgt[CW-1:0];
          q_cmd.top    = top[RW-1:0];
          q_cmd.bottom = bot[RW-1:0];
        end
      end
      REQ_TAKE: begin
        q_cmd.op = OP_TAKE;
      end
      REQ_READ: begin
        if (pix_in) begin
          q_cmd.op   = OP_READ;
          q_cmd.left = xs[CW-1:0];
          q_cmd.top  = ys[RW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/rfe_queue.sv
module rfe_queue import rfe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic empty
);

  cmd_t             slot_r [Q_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;

  assign full   = (cnt_r == (QAW+1)'(Q_DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_cmd = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < (QAW+1)'(Q_DEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("queue pop while empty");

endmodule

// File: design/rfe_back.sv
module rfe_back import rfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  rfe_rsp_if.source  rsp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_RD_MEM,
    ST_RD_OUT
  } state_t;

  logic [PIX_W-1:0] mem [MEM_D];

  state_t           state_r, state_nxt;
  logic [XW-1:0]    xx_r, xx_nxt;
  logic [YW-1:0]    yy_r, yy_nxt;
  logic [CW-1:0]    cur_left_r, cur_left_nxt;
  logic [CW-1:0]    cur_right_r, cur_right_nxt;
  logic [RW-1:0]    cur_bottom_r, cur_bottom_nxt;
  logic             cur_pat_r, cur_pat_nxt;
  logic [PIX_W-1:0] cur_color_r, cur_color_nxt;

  logic [CW-1:0]    box_left_r, box_left_nxt;
  logic [CW-1:0]    box_right_r, box_right_nxt;
  logic [RW-1:0]    box_top_r, box_top_nxt;
  logic [RW-1:0]    box_bottom_r, box_bottom_nxt;

  logic             wr_en_r, wr_en_nxt;
  logic [AW-1:0]    wr_addr_r, wr_addr_nxt;
  logic [PIX_W-1:0] wr_data_r, wr_data_nxt;
  logic [AW-1:0]    rd_addr_r, rd_addr_nxt;
  logic [PIX_W-1:0] rd_data_r;

  logic             out_valid_r, out_valid_nxt;
  logic             out_dirty_r, out_dirty_nxt;
  logic [BXW-1:0]   out_bx_r, out_bx_nxt;
  logic [BYW-1:0]   out_by_r, out_by_nxt;
  logic [BXW-1:0]   out_bw_r, out_bw_nxt;
  logic [BYW-1:0]   out_bh_r, out_bh_nxt;
  logic [PIX_W-1:0] out_pix_r, out_pix_nxt;

  logic             out_free;
  logic             box_empty;
  logic             last_col;
  logic             last_row;

  assign out_free  = !out_valid_r || rsp.ready;
  assign box_empty = (box_left_r >= box_right_r);
  assign last_col  = ((CW'(xx_r) + CW'(1)) == cur_right_r);
  assign last_row  = ((RW'(yy_r) + RW'(1)) == cur_bottom_r);

  assign rsp.valid       = out_valid_r;
  assign rsp.dirty_valid = out_dirty_r;
  assign rsp.box_x       = out_bx_r;
  assign rsp.box_y       = out_by_r;
  assign rsp.box_w       = out_bw_r;
  assign rsp.box_h       = out_bh_r;
  assign rsp.pixel_out   = out_pix_r;

  // Sequencer: pop commands, raster rectangles, read pixels, load results
  always_comb begin
    state_nxt      = state_r;
    xx_nxt         = xx_r;
    yy_nxt         = yy_r;
    cur_left_nxt   = cur_left_r;
    cur_right_nxt  = cur_right_r;
    cur_bottom_nxt = cur_bottom_r;
    cur_pat_nxt    = cur_pat_r;
    cur_color_nxt  = cur_color_r;
    box_left_nxt   = box_left_r;
    box_right_nxt  = box_right_r;
    box_top_nxt    = box_top_r;
    box_bottom_nxt = box_bottom_r;
    wr_en_nxt      = 1'b0;
    wr_addr_nxt    = wr_addr_r;
    wr_data_nxt    = wr_data_r;
    rd_addr_nxt    = rd_addr_r;
    out_valid_nxt  = out_valid_r && !rsp.ready;
    out_dirty_nxt  = out_dirty_r;
    out_bx_nxt     = out_bx_r;
    out_by_nxt     = out_by_r;
    out_bw_nxt     = out_bw_r;
    out_bh_nxt     = out_bh_r;
    out_pix_nxt    = out_pix_r;
    q_pop          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;

          // Grow the dirty box by the command's area
          if (q_cmd.grow) begin
            if (box_empty) begin
              box_left_nxt   = q_cmd.left;
              box_right_nxt  = q_cmd.right;
              box_top_nxt    = q_cmd.top;
              box_bottom_nxt = q_cmd.bottom;
            end else begin
              if (q_cmd.left < box_left_r) box_left_nxt = q_cmd.left;
              if (q_cmd.right > box_right_r) box_right_nxt = q_cmd.right;
              if (q_cmd.top < box_top_r) box_top_nxt = q_cmd.top;
              if (q_cmd.bottom > box_bottom_r) box_bottom_nxt = q_cmd.bottom;
            end
          end

          // Zero result by default; read loads its own later
          out_dirty_nxt = 1'b0;
          out_bx_nxt    = '0;
          out_by_nxt    = '0;
          out_bw_nxt    = '0;
          out_bh_nxt    = '0;
          out_pix_nxt   = '0;

          unique case (q_cmd.op)
            OP_DRAW: begin
              out_valid_nxt  = 1'b1;
              xx_nxt         = q_cmd.left[XW-1:0];
              yy_nxt         = q_cmd.top[YW-1:0];
              cur_left_nxt   = q_cmd.left;
              cur_right_nxt  = q_cmd.right;
              cur_bottom_nxt = q_cmd.bottom;
              cur_pat_nxt    = q_cmd.pat;
              cur_color_nxt  = q_cmd.color;
              state_nxt      = ST_DRAW;
            end
            OP_READ: begin
              rd_addr_nxt = AW'(AW'(q_cmd.top) * AW'(SCREEN_W)) + AW'(q_cmd.left);
              state_nxt   = ST_RD_MEM;
            end
            OP_TAKE: begin
              out_valid_nxt = 1'b1;
              if (!box_empty) begin
                out_dirty_nxt = 1'b1;
                out_bx_nxt    = BXW'(box_left_r);
                out_by_nxt    = BYW'(box_top_r);
                out_bw_nxt    = BXW'(box_right_r - box_left_r);
                out_bh_nxt    = BYW'(box_bottom_r - box_top_r);
                box_left_nxt  = '0;
                box_right_nxt = '0;
              end
            end
            OP_NONE: begin
              out_valid_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      ST_DRAW: begin
        // Issue one pixel write, then step the cursor
        wr_en_nxt   = 1'b1;
        wr_addr_nxt = AW'(AW'(yy_r) * AW'(SCREEN_W)) + AW'(xx_r);
        wr_data_nxt = cur_pat_r ? pattern_rgb565(xx_r, yy_r) : cur_color_r;
        if (last_col) begin
          xx_nxt = cur_left_r[XW-1:0];
          if (last_row) begin
            state_nxt = ST_IDLE;
          end else begin
            yy_nxt = yy_r + YW'(1);
          end
        end else begin
          xx_nxt = xx_r + XW'(1);
        end
      end

      ST_RD_MEM: begin
        state_nxt = ST_RD_OUT;
      end

      ST_RD_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dirty_nxt = 1'b0;
          out_bx_nxt    = '0;
          out_by_nxt    = '0;
          out_bw_nxt    = '0;
          out_bh_nxt    = '0;
          out_pix_nxt   = rd_data_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      box_left_r   <= '0;
      box_right_r  <= '0;
      box_top_r    <= '0;
      box_bottom_r <= '0;
      wr_en_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      box_left_r   <= box_left_nxt;
      box_right_r  <= box_right_nxt;
      box_top_r    <= box_top_nxt;
      box_bottom_r <= box_bottom_nxt;
      wr_en_r      <= wr_en_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    xx_r         <= xx_nxt;
    yy_r         <= yy_nxt;
    cur_left_r   <= cur_left_nxt;
    cur_right_r  <= cur_right_nxt;
    cur_bottom_r <= cur_bottom_nxt;
    cur_pat_r    <= cur_pat_nxt;
    cur_color_r  <= cur_color_nxt;
    wr_addr_r    <= wr_addr_nxt;
    wr_data_r    <= wr_data_nxt;
    rd_addr_r    <= rd_addr_nxt;
    out_dirty_r  <= out_dirty_nxt;
    out_bx_r     <= out_bx_nxt;
    out_by_r     <= out_by_nxt;
    out_bw_r     <= out_bw_nxt;
    out_bh_r     <= out_bh_nxt;
    out_pix_r    <= out_pix_nxt;
  end

  // Pixel memory write port
  always_ff @(posedge clk) begin
    if (wr_en_r) begin
      mem[wr_addr_r] <= wr_data_r;
    end
  end

  // Pixel memory read port
  always_ff @(posedge clk) begin
    if (state_r == ST_RD_MEM) begin
      rd_data_r <= mem[rd_addr_r];
    end
  end

  a_draw_in_rect: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAW) |-> (CW'(xx_r) < cur_right_r && RW'(yy_r) < cur_bottom_r))
    else $error("draw cursor left the rectangle");

  a_box_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (box_left_r < box_right_r) |->
      (box_right_r <= CW'(SCREEN_W) && box_bottom_r <= RW'(SCREEN_H) &&
       box_top_r < box_bottom_r))
    else $error("dirty box outside the screen");

  a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD_MEM) |=> (state_r == ST_RD_OUT))
    else $error("read data step skipped");

endmodule

// File: design/rect_fill_engine_dirty_box_unit.sv
// Channel   Dir  Handshake      Payload
// in_req    in   valid/ready    req_type, x_pos, y_pos, rect_w, rect_h, color
// out_rsp   out  valid/ready    dirty_valid, box_x, box_y, box_w, box_h, pixel_out
//
// Mark dirty, take dirty and no-op items are answered from the idle state of the back end.
// Pixel write, fill, pattern and clear raster their clipped area (clear: all 640*480 pixels),
// one pixel per cycle through the single write port. Read passes through ST_RD_MEM, ST_RD_OUT.
// A result is loaded into the output register after its item has left the queue.
// Reset clears the dirty box, queue and control; pixel memory keeps no reset value.
// Either side may stall; the queue and output register keep items in order.
module rect_fill_engine_dirty_box_unit import rfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rfe_req_if.sink    in_req,
  rfe_rsp_if.source  out_rsp
);

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  // Accept and classify items
  rfe_front u_front (
    .req    (in_req),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  // Decouple front from back
  rfe_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (push_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .rd_cmd (head_cmd),
    .empty  (q_empty)
  );

  // Execute commands against memory and dirty box
  rfe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (head_cmd),
    .q_pop   (q_pop),
    .rsp     (out_rsp)
  );

endmodule

// File: tb/rfe_frame_checker.sv
module rfe_frame_checker (
  input  logic clk,
  input  logic rst_n,
  rfe_req_if   req,
  rfe_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import rfe_pkg::*;

  typedef struct packed {
    logic             dirty_valid;
    logic [BXW-1:0]   box_x;
    logic [BYW-1:0]   box_y;
    logic [BXW-1:0]   box_w;
    logic [BYW-1:0]   box_h;
    logic [PIX_W-1:0] pixel_out;
  } box_rsp_t;

  // Color bars, left to right: white, yellow, cyan, green, magenta, red, blue, black
  localparam logic [PIX_W-1:0] BAR_RGB [8] = '{
    16'hFFFF, 16'hFFE0, 16'h07FF, 16'h07E0, 16'hF81F, 16'hF800, 16'h001F, 16'h0000
  };

  // Shadow copy of the pixel memory and the dirty box (half-open edges)
  bit [PIX_W-1:0] frame [MEM_D];
  int             dirty_l, dirty_t, dirty_r, dirty_b;
  box_rsp_t       rsp_q [$];

  // Expected pixel of the test pattern at one screen position
  function automatic logic [PIX_W-1:0] test_pattern_rgb(int col, int row);
    int bar;
    int g;
    if (row < (SCREEN_H * 2) / 3) begin
      bar = col / (SCREEN_W / 8);
      if (bar > 7) bar = 7;
      return BAR_RGB[bar];
    end
    g = col * 255 / (SCREEN_W - 1);
    return PIX_W'(((g & 'hF8) << 8) | ((g & 'hFC) << 3) | (g >> 3));
  endfunction

  // Merge a non-empty area into the dirty box; an empty box takes it whole
  function automatic void grow_dirty(int l, int t, int r, int b);
    if (l < r && t < b) begin
      if (dirty_l >= dirty_r) begin
        dirty_l = l;
        dirty_t = t;
        dirty_r = r;
        dirty_b = b;
      end else begin
        if (l < dirty_l) dirty_l = l;
        if (t < dirty_t) dirty_t = t;
        if (r > dirty_r) dirty_r = r;
        if (b > dirty_b) dirty_b = b;
      end
    end
  endfunction

  // Apply one command to the shadow state and return the result it must produce
  function automatic box_rsp_t predict_command(logic [REQ_W-1:0] code, int x, int y,
                                               int w, int h, logic [PIX_W-1:0] rgb);
    box_rsp_t res;
    int       l, t, r, b;
    int       row, col;
    res = '0;
    l = (x < 0) ? 0 : x;
    t = (y < 0) ? 0 : y;
    r = x + w;
    b = y + h;
    if (r > SCREEN_W) r = SCREEN_W;
    if (b > SCREEN_H) b = SCREEN_H;
    case (code)
      REQ_PIXEL: begin
        if (x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H) begin
          frame[y * SCREEN_W + x] = rgb;
          grow_dirty(x, y, x + 1, y + 1);
        end
      end
      REQ_FILL, REQ_PATTERN: begin
        for (row = t; row < b; row++) begin
          for (col = l; col < r; col++) begin
            frame[row * SCREEN_W + col] = (code == REQ_FILL) ? rgb
                                                             : test_pattern_rgb(col, row);
          end
        end
        grow_dirty(l, t, r, b);
      end
      REQ_CLEAR: begin
        foreach (frame[i]) frame[i] = rgb;
        grow_dirty(0, 0, SCREEN_W, SCREEN_H);
      end
      REQ_MARK: begin
        grow_dirty(l, t, r, b);
      end
      REQ_TAKE: begin
        // report the box, then empty it; top and bottom rows stay
        if (dirty_l < dirty_r) begin
          res.dirty_valid = 1'b1;
          res.box_x       = BXW'(dirty_l);
          res.box_y       = BYW'(dirty_t);
          res.box_w       = BXW'(dirty_r - dirty_l);
          res.box_h       = BYW'(dirty_b - dirty_t);
          dirty_l         = 0;
          dirty_r         = 0;
        end
      end
      REQ_READ: begin
        if (x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H) begin
          res.pixel_out = frame[y * SCREEN_W + x];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Compare each accepted result with the oldest prediction, then predict new items
  always @(posedge clk) begin
    box_rsp_t want;
    if (!rst_n) begin
      dirty_l    = 0;
      dirty_t    = 0;
      dirty_r    = 0;
      dirty_b    = 0;
      fail_count = 0;
      rsp_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (rsp_q.size() == 0) begin
          $error("result item arrived with no command waiting");
          fail_count++;
        end else begin
          want = rsp_q.pop_front();
          check_field("dirty_valid", want.dirty_valid, rsp.dirty_valid);
          check_field("box_x", want.box_x, rsp.box_x);
          check_field("box_y", want.box_y, rsp.box_y);
          check_field("box_w", want.box_w, rsp.box_w);
          check_field("box_h", want.box_h, rsp.box_h);
          check_field("pixel_out", want.pixel_out, rsp.pixel_out);
        end
      end
      if (req.valid && req.ready) begin
        rsp_q.push_back(predict_command(req.req_type, req.x_pos, req.y_pos,
                                        req.rect_w, req.rect_h, req.color));
      end
    end
    pending <= rsp_q.size();
  end

endmodule

// File: tb/rect_fill_engine_dirty_box_unit_tb.sv
module rect_fill_engine_dirty_box_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfe_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
  localparam int RAND_ITEMS   = 1100;
  localparam int PHASE_ITEMS  = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  // two full clears of 307200 pixels each dominate the run
  localparam int CYCLE_LIMIT  = 3_000_000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_cnt;
  int   tx_idle_pct;
  int   rx_stall_pct;
  bit   hold_req;

  rfe_req_if req_ch ();
  rfe_rsp_if rsp_ch ();

  rect_fill_engine_dirty_box_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  rfe_frame_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("rect_fill_engine_dirty_box_unit verification failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int  hold_left;
    bit  hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    rsp_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_used) begin
        hold_left = HOLD_CYCLES;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic int rand13();
    return int'($urandom_range(8191)) - 4096;
  endfunction

  // Start of a span inside one of three busy zones, so reads find drawn pixels
  function automatic int hot_start(int extent, int span);
    case ($urandom_range(2))
      0: return $urandom_range(20, 0);
      1: return extent - span - int'($urandom_range(20, 0));
      default: return extent / 2 + int'($urandom_range(20, 0));
    endcase
  endfunction

  // One axis of a rectangle that clips to span pixels, often hanging off an edge
  task automatic area_axis(input int extent, input int span, output int pos, output int len);
    int off;
    pos = hot_start(extent, span);
    len = span;
    case ($urandom_range(5))
      0: begin
        off = $urandom_range(4095 - span, 1);
        pos = -off;
        len = span + off;
      end
      1: begin
        pos = extent - span;
        len = span + int'($urandom_range(4095 - span, 0));
      end
      default: ;
    endcase
  endtask

  // Offer one item at the falling edge and hold it until accepted
  task automatic send_cmd(logic [REQ_W-1:0] code, int x, int y, int w, int h, int rgb);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= code;
    req_ch.x_pos    <= POS_W'(x);
    req_ch.y_pos    <= POS_W'(y);
    req_ch.rect_w   <= POS_W'(w);
    req_ch.rect_h   <= POS_W'(h);
    req_ch.color    <= PIX_W'(rgb);
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Fill or pattern with a bounded clipped area; some come out empty
  task automatic send_rect(logic [REQ_W-1:0] code);
    int x, y, w, h, sw, sh;
    if ($urandom_range(19) == 0) begin
      sw = $urandom_range(64, 1);
      sh = $urandom_range(48, 1);
    end else begin
      sw = $urandom_range(8, 1);
      sh = $urandom_range(8, 1);
    end
    area_axis(SCREEN_W, sw, x, w);
    area_axis(SCREEN_H, sh, y, h);
    case ($urandom_range(9))
      0: w = -int'($urandom_range(4096, 0));
      1: begin
        x = $urandom_range(4095, SCREEN_W);
        w = rand13();
      end
      2: begin
        y = -int'($urandom_range(4095, 1));
        h = $urandom_range(-y, 0);
      end
      default: ;
    endcase
    send_cmd(code, x, y, w, h, $urandom_range(65535));
  endtask

  initial begin
    int k, sel, x, y, w, h;
    rst_n           = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_PIXEL;
    req_ch.x_pos    = '0;
    req_ch.y_pos    = '0;
    req_ch.rect_w   = '0;
    req_ch.rect_h   = '0;
    req_ch.color    = '0;
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    hold_req        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset box, pixel corners, off-screen, clear, clipping, pattern, marks
    send_cmd(REQ_TAKE, 0, 0, 0, 0, 0);
    send_cmd(REQ_PIXEL, 0, 0, 0, 0, 'hFFFF);
    send_cmd(REQ_PIXEL, SCREEN_W - 1, SCREEN_H - 1, 0, 0, 'h8001);
    send_cmd(REQ_READ, 0, 0, 0, 0, 0);
    send_cmd(REQ_READ, SCREEN_W - 1, SCREEN_H - 1, 0, 0, 0);
    send_cmd(REQ_PIXEL, -1, 0, 1, 1, 'h1111);
    send_cmd(REQ_PIXEL, SCREEN_W, SCREEN_H - 1, 1, 1, 'h2222);
    send_cmd(REQ_READ, -4096, -4096, 0, 0, 0);
    send_cmd(REQ_TAKE, 0, 0, 0, 0, 0);
    send_cmd(REQ_TAKE, 0, 0, 0, 0, 0);
    send_cmd(REQ_CLEAR, 0, 0, 0, 0, 'h5AA5);
    send_cmd(REQ_FILL, -4096, -4096, 4095, 4095, 'h1234);
    send_cmd(REQ_FILL, SCREEN_W - 10, SCREEN_H - 10, 4095, 4095, 'h7E0F);
    send_cmd(REQ_FILL, 5, 5, -4096, 3, 'hABCD);
    send_cmd(REQ_READ, SCREEN_W - 5, SCREEN_H - 5, 0, 0, 0);
    send_cmd(REQ_PATTERN, 0, (SCREEN_H * 2) / 3 - 2, SCREEN_W, 4, 'hFFFF);
    send_cmd(REQ_READ, 100, (SCREEN_H * 2) / 3 - 1, 0, 0, 0);
    send_cmd(REQ_READ, SCREEN_W - 1, (SCREEN_H * 2) / 3, 0, 0, 0);
    send_cmd(REQ_TAKE, 0, 0, 0, 0, 0);
    send_cmd(REQ_MARK, -4096, -4096, 4095, 4095, 0);
    send_cmd(REQ_MARK, -100, -100, 200, 200, 0);
    send_cmd(REQ_MARK, 300, 200, 10, 5, 0);
    send_cmd(REQ_TAKE, 0, 0, 0, 0, 0);
    send_cmd(REQ_UNUSED, 4095, -4096, 4095, -4096, 'hFFFF);

    // Random mix, stepping through the idle and stall phases
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k % PHASE_ITEMS == 0) begin
        case ((k / PHASE_ITEMS) % 4)
          0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
          1: begin tx_idle_pct = 78; rx_stall_pct = 0;  end
          2: begin tx_idle_pct = 0;  rx_stall_pct = 78; end
          default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
        endcase
      end
      // long result hold-off while the sender keeps offering items
      if (k == 2 * PHASE_ITEMS + 10) hold_req = 1'b1;
      sel = $urandom_range(99);
      if (k == 600) begin
        send_cmd(REQ_CLEAR, rand13(), rand13(), rand13(), rand13(), $urandom_range(65535));
      end else if (sel < 18) begin
        if ($urandom_range(6) == 0) begin
          x = rand13();
          y = rand13();
        end else begin
          x = hot_start(SCREEN_W, 1);
          y = hot_start(SCREEN_H, 1);
        end
        send_cmd(REQ_PIXEL, x, y, rand13(), rand13(), $urandom_range(65535));
      end else if (sel < 32) begin
        send_rect(REQ_FILL);
      end else if (sel < 40) begin
        send_rect(REQ_PATTERN);
      end else if (sel < 52) begin
        if ($urandom_range(1) == 0) begin
          send_cmd(REQ_MARK, rand13(), rand13(), rand13(), rand13(), $urandom_range(65535));
        end else begin
          area_axis(SCREEN_W, $urandom_range(40, 1), x, w);
          area_axis(SCREEN_H, $urandom_range(40, 1), y, h);
          send_cmd(REQ_MARK, x, y, w, h, $urandom_range(65535));
        end
      end else if (sel < 64) begin
        send_cmd(REQ_TAKE, rand13(), rand13(), rand13(), rand13(), $urandom_range(65535));
      end else if (sel < 97) begin
        case ($urandom_range(9))
          0: begin
            x = rand13();
            y = rand13();
          end
          1: begin
            x = $urandom_range(SCREEN_W - 1);
            y = $urandom_range(SCREEN_H - 1);
          end
          default: begin
            x = hot_start(SCREEN_W, 1);
            y = hot_start(SCREEN_H, 1);
          end
        endcase
        send_cmd(REQ_READ, x, y, rand13(), rand13(), $urandom_range(65535));
      end else begin
        send_cmd(REQ_UNUSED, rand13(), rand13(), rand13(), rand13(), $urandom_range(65535));
      end
    end
    req_ch.valid <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("rect_fill_engine_dirty_box_unit verification clean");
    end else begin
      $display("rect_fill_engine_dirty_box_unit verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/rfe_pkg.sv
design/rfe_req_if.sv
design/rfe_rsp_if.sv
design/rfe_front.sv
design/rfe_queue.sv
design/rfe_back.sv
design/rect_fill_engine_dirty_box_unit.sv
tb/rfe_frame_checker.sv
tb/rect_fill_engine_dirty_box_unit_tb.sv
